>>> hdl/esg_pkg.sv
package esg_pkg;

	localparam int MaxStepsDef  = 64;
	localparam int CoordBitsDef = 30;
	localparam int GridBits     = 20;
	localparam logic [GridBits-1:0] GridReset = 20'd1;

	typedef enum logic [1:0] {
		KIND_VERT  = 2'd0,
		KIND_HORIZ = 2'd1,
		KIND_XSTEP = 2'd2,
		KIND_YSTEP = 2'd3
	} kind_t;

	// back-end walk states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_FIRST,
		BK_STEP,
		BK_MUL,
		BK_DIV,
		BK_MOD,
		BK_SNAP
	} bk_state_t;

endpackage

>>> hdl/edge_staircase_generator_top.sv
// channel | dir | handshake               | payload
// in      | in  | in_valid / in_ready     | origin_x origin_y end_x end_y
// out     | out | out_valid / out_ready   | edge_kind .. truncated
// cfg     | in  | cfg_valid / cfg_ready   | cfg_data (grid pitch)
// the first result of an edge is registered from the BK_FIRST state once the
// output register is free; each further result of a walked edge waits on the
// shared bit-serial divider that does the line division and then
// the grid modulo
// a two-entry edge queue lets the front accept while the walk runs
// a stalled output holds the walk; reset clears the queue and the walker
module edge_staircase_generator_top #(
	parameter int COORD_BITS = esg_pkg::CoordBitsDef,
	parameter int MAX_STEPS  = esg_pkg::MaxStepsDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [COORD_BITS-1:0] origin_x,
	input  logic signed [COORD_BITS-1:0] origin_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] edge_kind,
	output logic x_rising,
	output logic y_rising,
	output logic signed [COORD_BITS-1:0] step_position,
	output logic signed [COORD_BITS-1:0] snapped_value,
	output logic last,
	output logic truncated,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [esg_pkg::GridBits-1:0] cfg_data
);
	import esg_pkg::*;

	logic [GridBits-1:0] grid_q;
	logic q_valid, q_pop, q_xr, q_yr;
	logic [1:0] q_kind;
	logic signed [COORD_BITS-1:0] q_os, q_es, q_oo;
	logic signed [COORD_BITS:0] q_ds, q_dd;

	assign cfg_ready = 1'b1;

	// grid pitch register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) grid_q <= GridReset;
		else if (cfg_valid) grid_q <= cfg_data;
	end

	esg_front #(.CB(COORD_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .origin_x, .origin_y, .end_x, .end_y,
		.q_valid, .q_pop, .q_kind, .q_xr, .q_yr, .q_os, .q_es, .q_oo, .q_ds, .q_dd
	);

	esg_back #(.CB(COORD_BITS), .MS(MAX_STEPS)) u_back (
		.clk, .arst_n, .grid(grid_q), .q_valid, .q_pop, .q_kind, .q_xr, .q_yr,
		.q_os, .q_es, .q_oo, .q_ds, .q_dd, .out_valid, .out_ready, .edge_kind,
		.x_rising, .y_rising, .step_position, .snapped_value, .last, .truncated
	);
endmodule

>>> hdl/esg_div.sv
// restoring divider, one quotient bit per cycle, unsigned magnitudes
module esg_div #(
	parameter int NB = 64,
	parameter int DB = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NB-1:0] num,
	input  logic [DB-1:0] den,
	output logic          done,
	output logic [NB-1:0] quo,
	output logic [DB-1:0] rem
);
	localparam int CB = $clog2(NB + 1);

	logic [CB-1:0] cnt_q;
	logic          busy_q;
	logic [NB-1:0] q_q;
	logic [DB:0]   r_q;
	logic [DB-1:0] d_q;
	logic [DB:0]   trial;

	assign trial = {r_q[DB-1:0], q_q[NB-1]} - {1'b0, d_q};

	// shift and subtract
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CB'(NB);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CB'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (!trial[DB]) begin
				r_q <= trial;
				q_q <= {q_q[NB-2:0], 1'b1};
			end else begin
				r_q <= {r_q[DB-1:0], q_q[NB-1]};
				q_q <= {q_q[NB-2:0], 1'b0};
			end
		end
	end

	// quotient and remainder hold once the shifting stops
	assign done = !busy_q;
	assign quo  = q_q;
	assign rem  = r_q[DB-1:0];
endmodule

>>> hdl/esg_front.sv
// accepts edges, classifies them and pushes a descriptor into a two-entry queue
module esg_front #(
	parameter int CB = esg_pkg::CoordBitsDef
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [CB-1:0]       origin_x,
	input  logic signed [CB-1:0]       origin_y,
	input  logic signed [CB-1:0]       end_x,
	input  logic signed [CB-1:0]       end_y,
	output logic                       q_valid,
	input  logic                       q_pop,
	output logic [1:0]                 q_kind,
	output logic                       q_xr,
	output logic                       q_yr,
	output logic signed [CB-1:0]       q_os,
	output logic signed [CB-1:0]       q_es,
	output logic signed [CB-1:0]       q_oo,
	output logic signed [CB:0]         q_ds,
	output logic signed [CB:0]         q_dd
);
	import esg_pkg::*;

	localparam int W = 2 + 2 + 3 * CB + 2 * (CB + 1);

	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;
	logic [W-1:0] wdata;

	logic signed [CB:0] dx, dy, adx, ady;
	logic               xr, yr, xs;
	kind_t              kind;

	// classify the edge
	always_comb begin
		dx  = (CB+1)'(end_x) - (CB+1)'(origin_x);
		dy  = (CB+1)'(end_y) - (CB+1)'(origin_y);
		adx = dx[CB] ? -dx : dx;
		ady = dy[CB] ? -dy : dy;
		xr  = end_x > origin_x;
		yr  = end_y > origin_y;
		xs  = ady > adx;
		if (origin_x == end_x)      kind = KIND_VERT;
		else if (origin_y == end_y) kind = KIND_HORIZ;
		else if (xs)                kind = KIND_XSTEP;
		else                        kind = KIND_YSTEP;
		if (kind == KIND_VERT || kind == KIND_HORIZ)
			wdata = {kind, xr, yr, origin_x, end_x, origin_y, dx, dy};
		else if (xs)
			wdata = {kind, xr, yr, origin_x, end_x, origin_y, dx, dy};
		else
			wdata = {kind, xr, yr, origin_y, end_y, origin_x, dy, dx};
	end

	assign in_ready = cnt_q != 2'd2;
	assign q_valid  = cnt_q != 2'd0;
	assign {q_kind, q_xr, q_yr, q_os, q_es, q_oo, q_ds, q_dd} = mem_q[rp_q];

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (q_pop && q_valid)     rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, in_valid && in_ready} - {1'b0, q_pop && q_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			mem_q[wp_q] <= wdata;
	end
endmodule

>>> hdl/esg_back.sv
// walks one edge descriptor and emits its results
module esg_back #(
	parameter int CB = esg_pkg::CoordBitsDef,
	parameter int MS = esg_pkg::MaxStepsDef
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [esg_pkg::GridBits-1:0] grid,
	input  logic                       q_valid,
	output logic                       q_pop,
	input  logic [1:0]                 q_kind,
	input  logic                       q_xr,
	input  logic                       q_yr,
	input  logic signed [CB-1:0]       q_os,
	input  logic signed [CB-1:0]       q_es,
	input  logic signed [CB-1:0]       q_oo,
	input  logic signed [CB:0]         q_ds,
	input  logic signed [CB:0]         q_dd,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 edge_kind,
	output logic                       x_rising,
	output logic                       y_rising,
	output logic signed [CB-1:0]       step_position,
	output logic signed [CB-1:0]       snapped_value,
	output logic                       last,
	output logic                       truncated
);
	import esg_pkg::*;

	localparam int NW = 2 * CB + 4;
	localparam int PW = CB + 22;
	localparam int SB = $clog2(MS + 1);

	bk_state_t st_q, st_d;
	logic [1:0]            kind_q;
	logic                  xr_q, yr_q, rise_q, up_q;
	logic signed [CB-1:0]  os_q, es_q, oo_q;
	logic signed [CB:0]    ds_q, dd_q;
	logic signed [PW-1:0]  pos_q, pnext;
	logic [SB-1:0]         n_q;
	logic [GridBits-1:0]   g_q;
	logic [GridBits-1:0]   gsel;
	logic signed [NW-1:0]  num_q;
	logic signed [NW-1:0]  dstep_q;
	logic signed [2*CB:0]  base_prod;
	logic signed [CB+GridBits+1:0] dstep_prod;
	logic signed [NW-1:0]  v_q;
	logic                  div_start;
	logic [NW-1:0]         dnum;
	logic [CB+1:0]         dden;
	logic                  div_done;
	logic [NW-1:0]         quo;
	logic [CB+1:0]         rem;
	logic                  oreg_free, past;
	logic signed [NW-1:0]  m;

	esg_div #(.NB(NW), .DB(CB + 2)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(dnum), .den(dden),
		.done(div_done), .quo(quo), .rem(rem)
	);

	assign oreg_free = !out_valid || out_ready;
	assign pnext = pos_q + (rise_q ? PW'($signed({1'b0, g_q})) : -PW'($signed({1'b0, g_q})));
	assign past  = rise_q ? (pnext > PW'(es_q)) : (pnext < PW'(es_q));

	// zero pitch acts as one
	assign gsel = (grid == '0) ? GridBits'(1) : grid;

	// line numerator at the origin and its change per grid step
	assign base_prod  = (2*CB+1)'(q_oo) * (2*CB+1)'(q_ds);
	assign dstep_prod = (CB+GridBits+2)'(q_dd) * (CB+GridBits+2)'($signed({1'b0, gsel}));

	// next-state logic
	always_comb begin
		st_d      = st_q;
		q_pop     = 1'b0;
		div_start = 1'b0;
		dnum      = '0;
		dden      = '0;
		case (st_q)
			BK_IDLE:  if (q_valid) st_d = BK_FIRST;
			BK_FIRST: if (oreg_free) begin
				q_pop = 1'b1;
				if (kind_q == KIND_VERT || kind_q == KIND_HORIZ) st_d = BK_IDLE;
				else if (past) st_d = BK_IDLE;
				else st_d = BK_STEP;
			end
			BK_STEP:  st_d = BK_MUL;
			BK_MUL: begin
				div_start = 1'b1;
				dnum = num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
				dden = ds_q[CB] ? (CB+2)'(-ds_q) : (CB+2)'(ds_q);
				st_d = BK_DIV;
			end
			BK_DIV:   if (div_done) st_d = BK_MOD;
			BK_MOD: begin
				div_start = 1'b1;
				dnum = v_q[NW-1] ? NW'(-v_q) : NW'(v_q);
				dden = (CB+2)'(g_q);
				st_d = BK_SNAP;
			end
			BK_SNAP:  if (div_done && oreg_free)
				st_d = (past || n_q == SB'(MS - 1)) ? BK_IDLE : BK_STEP;
			default:  st_d = BK_IDLE;
		endcase
	end

	// floor modulo from magnitude remainder
	always_comb begin
		m = NW'($signed({1'b0, rem}));
		if (v_q[NW-1] && rem != '0) m = NW'($signed({1'b0, g_q})) - m;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= BK_IDLE;
			out_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (st_q == BK_FIRST && oreg_free) out_valid <= 1'b1;
			if (st_q == BK_SNAP && div_done && oreg_free) out_valid <= 1'b1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (st_q == BK_IDLE && q_valid) begin
			kind_q <= q_kind; xr_q <= q_xr; yr_q <= q_yr;
			os_q <= q_os; es_q <= q_es; oo_q <= q_oo; ds_q <= q_ds; dd_q <= q_dd;
			rise_q <= (q_kind == KIND_XSTEP) ? q_xr : q_yr;
			up_q   <= (q_kind == KIND_XSTEP) ? !q_xr : q_yr;
			pos_q  <= PW'(q_os);
			g_q    <= gsel;
			num_q  <= NW'(base_prod);
			dstep_q <= NW'(dstep_prod);
			n_q    <= SB'(1);
		end
		if (st_q == BK_FIRST && oreg_free) begin
			edge_kind <= kind_q; x_rising <= xr_q; y_rising <= yr_q;
			step_position <= os_q; snapped_value <= oo_q;
			last <= (kind_q == KIND_VERT || kind_q == KIND_HORIZ) || past;
			truncated <= 1'b0;
		end
		// advance one pitch and the numerator with it
		if (st_q == BK_STEP) begin
			pos_q <= pnext;
			num_q <= rise_q ? num_q + dstep_q : num_q - dstep_q;
		end
		if (st_q == BK_DIV && div_done)
			v_q <= (num_q[NW-1] ^ ds_q[CB]) ? -$signed(quo) : $signed(quo);
		if (st_q == BK_SNAP && div_done && oreg_free) begin
			edge_kind <= kind_q; x_rising <= xr_q; y_rising <= yr_q;
			step_position <= CB'(pos_q);
			if (m == '0) snapped_value <= CB'(v_q);
			else if (up_q) snapped_value <= CB'(v_q + NW'($signed({1'b0, g_q})) - m);
			else snapped_value <= CB'(v_q - m);
			last <= past || n_q == SB'(MS - 1);
			truncated <= !past && n_q == SB'(MS - 1);
			n_q <= n_q + 1'b1;
		end
	end
endmodule

>>> hdl/esg_checker.sv
module esg_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic last,
	input logic truncated,
	input logic [1:0] edge_kind
);
	import esg_pkg::*;

	// truncation only flagged on a final item
	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && truncated |-> last) else $error("truncated without last");

	// axis-aligned edges give a single item
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (edge_kind == KIND_VERT || edge_kind == KIND_HORIZ) |-> last)
		else $error("axis edge not last");

	// a stalled output holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(last))
		else $error("output dropped");
endmodule

bind edge_staircase_generator_top esg_checker u_chk (
	.clk, .arst_n, .out_valid, .out_ready, .last, .truncated, .edge_kind
);
